>>> sv/clcg_pkg.sv
// Shared types and constants of the combined LCG shuffle generator.
package clcg_pkg;

  // Shuffle table geometry.
  localparam int TABLE_DEPTH = 32;
  localparam int WARMUP      = 8;
  localparam int SEED_STEPS  = TABLE_DEPTH + WARMUP;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int QUO_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W       = $clog2(SEED_STEPS);

  // Datapath widths.
  localparam int WORD_W = 31;
  localparam int FOLD_W = WORD_W + 1;
  localparam int A_W    = 16;
  localparam int C_W    = 8;
  localparam int PROD_W = WORD_W + A_W;

  // Moduli, multipliers and the folding constants 2^31 - m.
  localparam logic [FOLD_W-1:0] TWO_W = 32'h8000_0000;
  localparam logic [FOLD_W-1:0] M1    = 32'd2147483563;
  localparam logic [FOLD_W-1:0] M2    = 32'd2147483399;
  localparam logic [FOLD_W-1:0] MM1   = M1 - 32'd1;
  localparam logic [C_W-1:0]    C1    = C_W'(TWO_W - M1);
  localparam logic [C_W-1:0]    C2    = C_W'(TWO_W - M2);
  localparam logic [A_W-1:0]    A1    = 16'd40014;
  localparam logic [A_W-1:0]    A2    = 16'd40692;

  localparam logic [WORD_W-1:0] GEN2_RESET = 31'd123456789;

  // Slot index is holder / SLOT_DIV, estimated as (holder * RECIP) >> RECIP_SHIFT.
  localparam logic [FOLD_W-1:0] SLOT_DIV    = FOLD_W'(32'd1 + MM1 / TABLE_DEPTH);
  localparam int                DIV_LOG     = $clog2(SLOT_DIV + 32'd1) - 1;
  localparam int                RECIP_SHIFT = A_W - 1 + DIV_LOG;
  localparam logic [A_W-1:0]    RECIP       =
    A_W'((64'd1 << RECIP_SHIFT) / 64'(SLOT_DIV));

  // Input op codes.
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  typedef enum logic {
    MOD_M1,
    MOD_M2
  } mod_sel_e;

  typedef struct packed {
    mod_sel_e          sel;
    logic [A_W-1:0]    a;
    logic [WORD_W-1:0] x;
  } mul_req_t;

endpackage

>>> sv/clcg_if.sv
// Handshake channels for the input items and the generated draws.
interface clcg_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [clcg_pkg::WORD_W-1:0]   seed_value;

  modport source (output valid, output op, output seed_value, input ready);
  modport sink (input valid, input op, input seed_value, output ready);
endinterface

interface clcg_out_if;
  logic                          valid;
  logic                          ready;
  logic [clcg_pkg::WORD_W-1:0]   draw;

  modport source (output valid, output draw, input ready);
  modport sink (input valid, input draw, output ready);
endinterface

>>> sv/combined_lcg_shuffle_rng_top.sv
// Combined LCG generator with shuffle table: sequencer, state and output register.
// A draw is accepted in idle and its result is registered after the division, generator
// and capture states; no new item is accepted until then (shared multiplier), and while
// the output is busy the result waits in the holder. A reseed, or a draw while the first
// generator is zero, adds 40 generator steps, each an issue, wait and capture state, first.
// Reset zeroes the first generator and the holder, loads the second with its start value
// and idles the control; the table is not cleared, as every draw path rewrites it first.
module combined_lcg_shuffle_rng_top (
  input  logic clk_i,
  input  logic rst_ni,
  clcg_in_if.sink    in_i,
  clcg_out_if.source out_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED_ISS,
    S_SEED_WAIT,
    S_SEED_CAP,
    S_DIV1,
    S_DIV2,
    S_GEN1,
    S_GEN2,
    S_CAP1,
    S_FIN,
    S_HOLD
  } state_e;

  state_e                          state_q, state_d;
  logic [clcg_pkg::WORD_W-1:0]     first_q, first_d;
  logic [clcg_pkg::WORD_W-1:0]     second_q, second_d;
  logic [clcg_pkg::WORD_W-1:0]     holder_q, holder_d;
  logic [clcg_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [clcg_pkg::QUO_W-1:0]      est_q, est_d;
  logic [clcg_pkg::SLOT_W-1:0]     slot_q, slot_d;
  logic                            out_valid_q, out_valid_d;
  logic [clcg_pkg::WORD_W-1:0]     out_draw_q, out_draw_d;

  clcg_pkg::mul_req_t              mul_req;
  logic [clcg_pkg::PROD_W-1:0]     mul_prod;
  logic [clcg_pkg::WORD_W-1:0]     mul_res;

  logic                            ram_we;
  logic [clcg_pkg::SLOT_W-1:0]     ram_waddr;
  logic [clcg_pkg::WORD_W-1:0]     ram_wdata;
  logic [clcg_pkg::WORD_W-1:0]     ram_rdata;

  logic [clcg_pkg::FOLD_W-1:0]     rem;
  logic [clcg_pkg::QUO_W-1:0]      quo;
  logic [clcg_pkg::FOLD_W-1:0]     diff;
  logic [clcg_pkg::FOLD_W-1:0]     diff_adj;
  logic [clcg_pkg::WORD_W-1:0]     new_draw;
  logic [clcg_pkg::WORD_W-1:0]     seed_word;
  logic                            out_free;

  clcg_mulmod u_mulmod (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_prod),
    .res_o  (mul_res)
  );

  clcg_ram #(
    .WIDTH (clcg_pkg::WORD_W),
    .DEPTH (clcg_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  // The reciprocal estimate is low by at most one, so one compare corrects it.
  assign rem = {1'b0, holder_q} - mul_prod[clcg_pkg::FOLD_W-1:0];
  assign quo = (rem >= clcg_pkg::SLOT_DIV) ? est_q + clcg_pkg::QUO_W'(1) : est_q;

  // Table entry minus the second generator, wrapped into 1..MM1.
  assign diff     = {1'b0, ram_rdata} - {1'b0, mul_res};
  assign diff_adj = (diff[clcg_pkg::FOLD_W-1] || diff == '0) ? diff + clcg_pkg::MM1 : diff;
  assign new_draw = diff_adj[clcg_pkg::WORD_W-1:0];

  assign seed_word = (in_i.seed_value == '0) ? clcg_pkg::WORD_W'(1) : in_i.seed_value;
  assign out_free  = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    second_d    = second_q;
    holder_d    = holder_q;
    cnt_d       = cnt_q;
    est_d       = est_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_draw_d  = out_draw_q;

    mul_req.sel = clcg_pkg::MOD_M1;
    mul_req.a   = clcg_pkg::A1;
    mul_req.x   = first_q;

    ram_we    = 1'b0;
    ram_waddr = cnt_q[clcg_pkg::SLOT_W-1:0];
    ram_wdata = mul_res;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.op == clcg_pkg::OP_RESEED) begin
            first_d  = seed_word;
            second_d = seed_word;
            cnt_d    = clcg_pkg::CNT_W'(clcg_pkg::SEED_STEPS - 1);
            state_d  = S_SEED_ISS;
          end else if (first_q == '0) begin
            // An unseeded or collapsed generator restarts from seed one.
            first_d  = clcg_pkg::WORD_W'(1);
            second_d = clcg_pkg::WORD_W'(1);
            cnt_d    = clcg_pkg::CNT_W'(clcg_pkg::SEED_STEPS - 1);
            state_d  = S_SEED_ISS;
          end else begin
            state_d = S_DIV1;
          end
        end
      end
      S_SEED_ISS: begin
        state_d = S_SEED_WAIT;
      end
      S_SEED_WAIT: begin
        state_d = S_SEED_CAP;
      end
      S_SEED_CAP: begin
        first_d = mul_res;
        if (cnt_q < clcg_pkg::CNT_W'(clcg_pkg::TABLE_DEPTH)) begin
          ram_we = 1'b1;
        end
        if (cnt_q == '0) begin
          holder_d = mul_res;
          state_d  = S_DIV1;
        end else begin
          cnt_d   = cnt_q - clcg_pkg::CNT_W'(1);
          state_d = S_SEED_ISS;
        end
      end
      S_DIV1: begin
        mul_req.a = clcg_pkg::RECIP;
        mul_req.x = holder_q;
        state_d   = S_DIV2;
      end
      S_DIV2: begin
        est_d     = mul_prod[clcg_pkg::RECIP_SHIFT +: clcg_pkg::QUO_W];
        mul_req.a = clcg_pkg::A_W'(est_d);
        mul_req.x = clcg_pkg::SLOT_DIV[clcg_pkg::WORD_W-1:0];
        state_d   = S_GEN1;
      end
      S_GEN1: begin
        if (quo >= clcg_pkg::QUO_W'(clcg_pkg::TABLE_DEPTH)) begin
          slot_d = clcg_pkg::SLOT_W'(clcg_pkg::TABLE_DEPTH - 1);
        end else begin
          slot_d = quo[clcg_pkg::SLOT_W-1:0];
        end
        state_d = S_GEN2;
      end
      S_GEN2: begin
        mul_req.sel = clcg_pkg::MOD_M2;
        mul_req.a   = clcg_pkg::A2;
        mul_req.x   = second_q;
        state_d     = S_CAP1;
      end
      S_CAP1: begin
        first_d = mul_res;
        state_d = S_FIN;
      end
      S_FIN: begin
        second_d  = mul_res;
        holder_d  = new_draw;
        ram_we    = 1'b1;
        ram_waddr = slot_q;
        ram_wdata = first_q;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_draw_d  = new_draw;
          state_d     = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_draw_d  = holder_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      first_q     <= '0;
      second_q    <= clcg_pkg::GEN2_RESET;
      holder_q    <= '0;
      cnt_q       <= '0;
      est_q       <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      out_draw_q  <= '0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      second_q    <= second_d;
      holder_q    <= holder_d;
      cnt_q       <= cnt_d;
      est_q       <= est_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
      out_draw_q  <= out_draw_d;
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.draw  = out_draw_q;

  // A delivered draw always lies in 1..MM1.
  a_draw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_draw_q != '0) && ({1'b0, out_draw_q} <= clcg_pkg::MM1))
    else $error("draw outside its range");

  // The slot estimate is never more than one below the true quotient.
  a_slot_est: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GEN1) |-> (rem < (clcg_pkg::SLOT_DIV + clcg_pkg::SLOT_DIV)))
    else $error("slot estimate off by more than one");

  // The first generator's step result is reduced below its modulus.
  a_gen1_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CAP1 || state_q == S_SEED_CAP) |-> ({1'b0, mul_res} < clcg_pkg::M1))
    else $error("first generator step not reduced");

  // The last seeding step leaves the holder equal to the first generator.
  a_seed_holder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEED_CAP && cnt_q == '0) |=> (holder_q == first_q) && (state_q == S_DIV1))
    else $error("holder not loaded at end of seeding");

endmodule

>>> sv/clcg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module clcg_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/clcg_mulmod.sv
// Shared two-stage multiplier with modular folding for both generators.
module clcg_mulmod (
  input  logic                                 clk_i,
  input  clcg_pkg::mul_req_t                   req_i,
  output logic [clcg_pkg::PROD_W-1:0]          prod_o,
  output logic [clcg_pkg::WORD_W-1:0]          res_o
);

  logic [clcg_pkg::PROD_W-1:0]          prod_q;
  clcg_pkg::mod_sel_e                   sel_q;
  clcg_pkg::mod_sel_e                   sel2_q;
  logic [clcg_pkg::FOLD_W-1:0]          fold_q;
  logic [clcg_pkg::FOLD_W-1:0]          fold_d;
  logic [clcg_pkg::A_W+clcg_pkg::C_W-1:0] hi_c;
  logic [clcg_pkg::C_W-1:0]             c_sel;
  logic [clcg_pkg::FOLD_W-1:0]          mod_val;

  // Since 2^31 = c (mod m), hi*2^31 + lo folds to hi*c + lo, which stays below 2m.
  always_comb begin
    c_sel  = (sel_q == clcg_pkg::MOD_M1) ? clcg_pkg::C1 : clcg_pkg::C2;
    hi_c   = prod_q[clcg_pkg::PROD_W-1 -: clcg_pkg::A_W] * c_sel;
    fold_d = clcg_pkg::FOLD_W'(hi_c) + clcg_pkg::FOLD_W'(prod_q[clcg_pkg::WORD_W-1:0]);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= clcg_pkg::PROD_W'(req_i.a) * clcg_pkg::PROD_W'(req_i.x);
    sel_q  <= req_i.sel;
    fold_q <= fold_d;
    sel2_q <= sel_q;
  end

  assign mod_val = (sel2_q == clcg_pkg::MOD_M1) ? clcg_pkg::M1 : clcg_pkg::M2;
  assign res_o   = (fold_q >= mod_val) ? clcg_pkg::WORD_W'(fold_q - mod_val)
                                       : fold_q[clcg_pkg::WORD_W-1:0];
  assign prod_o  = prod_q;

endmodule
